FILE: rtl/core/spi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spi_pkg;

  // Default number of servo channels
  localparam int CHANNELS_DEF = 12;

  // Blend duration after reset, in ms
  localparam logic [15:0] DUR_RESET = 16'd900;

  // Angle limit: 180 degrees in 1/256 degree
  localparam logic [15:0] ANGLE_MAX = 16'd46080;

  // Blend fraction is Q0.16, so 1.0 needs one more bit
  localparam int          T_FRAC_W = 16;
  localparam logic [16:0] T_ONE    = 17'h10000;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Input item modes
  typedef enum logic [1:0] {
    MODE_LOAD_START = 2'd0,
    MODE_LOAD_END   = 2'd1,
    MODE_BEGIN      = 2'd2,
    MODE_TICK       = 2'd3
  } mode_t;

  // Work handed from front to back
  typedef enum logic [1:0] {
    OP_LOAD_START = 2'd0,
    OP_LOAD_END   = 2'd1,
    OP_TICK       = 2'd2
  } op_t;

  // How the back obtains the blend fraction of a tick
  typedef enum logic [1:0] {
    TS_ZERO = 2'd0,
    TS_ONE  = 2'd1,
    TS_DIV  = 2'd2
  } tsel_t;

  typedef struct packed {
    op_t                op;
    tsel_t              tsel;
    logic [3:0]         channel;
    logic signed [16:0] angle;
    logic [31:0]        elapsed;
    logic [31:0]        total;
    logic               still_active;
    logic               freeze;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/core/spi_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [3:0]         channel;
  logic signed [16:0] pose_angle;
  logic               hold_after;
  logic [31:0]        now_ms;

  modport source (output valid, mode, channel, pose_angle, hold_after, now_ms,
                  input ready);
  modport sink (input valid, mode, channel, pose_angle, hold_after, now_ms,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spi_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spi_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_channel;
  logic [15:0] angle;
  logic        last;
  logic        still_active;
  logic        freeze;

  modport source (output valid, out_channel, angle, last, still_active, freeze,
                  input ready);
  modport sink (input valid, out_channel, angle, last, still_active, freeze,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spi_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spi_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] blend_duration_ms;

  modport source (output valid, blend_duration_ms, input ready);
  modport sink (input valid, blend_duration_ms, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spi_front.sv
`timescale 1ns / 1ps
`default_nettype none
module spi_front #(
  parameter int CHANNELS = spi_pkg::CHANNELS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  spi_in_if.sink          in_ch,
  spi_cfg_if.sink         cfg_ch,
  output spi_pkg::job_t   push_job,
  output logic            push_valid,
  input  wire logic       q_full
);

  logic [15:0] dur_r;
  logic [31:0] start_time_r;
  logic [31:0] end_time_r;
  logic        active_r;
  logic        hold_r;
  logic        freeze_r;

  logic        accept;
  logic [31:0] total_raw;
  logic [31:0] total;
  logic [31:0] elapsed;
  logic        done;
  logic        in_range;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  // Classify the tick: finished, before start, or inside the blend
  assign total_raw = end_time_r - start_time_r;
  assign total     = ($signed(total_raw) <= 32'sd0) ? 32'd1 : total_raw;
  assign elapsed   = in_ch.now_ms - start_time_r;
  assign done      = $signed(elapsed) >= $signed(total);
  assign in_range  = 32'(in_ch.channel) < CHANNELS;

  // Build the job for the back
  always_comb begin
    push_job.op           = spi_pkg::OP_TICK;
    push_job.tsel         = spi_pkg::TS_DIV;
    push_job.channel      = in_ch.channel;
    push_job.angle        = in_ch.pose_angle;
    push_job.elapsed      = elapsed;
    push_job.total        = total;
    push_job.still_active = !done;
    push_job.freeze       = done ? hold_r : freeze_r;
    push_valid            = 1'b0;
    if (done) begin
      push_job.tsel = spi_pkg::TS_ONE;
    end else if (elapsed[31]) begin
      push_job.tsel = spi_pkg::TS_ZERO;
    end
    unique case (in_ch.mode)
      spi_pkg::MODE_LOAD_START: begin
        push_job.op = spi_pkg::OP_LOAD_START;
        push_valid  = accept && in_range;
      end
      spi_pkg::MODE_LOAD_END: begin
        push_job.op = spi_pkg::OP_LOAD_END;
        push_valid  = accept && in_range;
      end
      spi_pkg::MODE_BEGIN: begin
        push_valid = 1'b0;
      end
      spi_pkg::MODE_TICK: begin
        push_valid = accept && active_r;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  // Hold the blend timing and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r        <= spi_pkg::DUR_RESET;
      start_time_r <= '0;
      end_time_r   <= '0;
      active_r     <= 1'b0;
      hold_r       <= 1'b0;
      freeze_r     <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        dur_r <= cfg_ch.blend_duration_ms;
      end
      if (accept && in_ch.mode == spi_pkg::MODE_BEGIN) begin
        start_time_r <= in_ch.now_ms;
        end_time_r   <= in_ch.now_ms + {16'd0, dur_r};
        hold_r       <= in_ch.hold_after;
        active_r     <= 1'b1;
        freeze_r     <= 1'b1;
      end else if (accept && in_ch.mode == spi_pkg::MODE_TICK && active_r && done) begin
        active_r <= 1'b0;
        freeze_r <= hold_r;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/spi_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module spi_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  input  wire spi_pkg::job_t push_job,
  output logic               q_full,
  input  wire logic          pop,
  output logic               q_valid,
  output spi_pkg::job_t      q_job
);

  localparam int PTR_W = (spi_pkg::QUEUE_DEPTH > 1) ? $clog2(spi_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(spi_pkg::QUEUE_DEPTH + 1);

  spi_pkg::job_t mem_r [spi_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign q_full  = count_r == CNT_W'(spi_pkg::QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push_valid && !q_full;
  assign do_pop  = pop && q_valid;

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(spi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(spi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/spi_back.sv
`timescale 1ns / 1ps
`default_nettype none
module spi_back #(
  parameter int CHANNELS = spi_pkg::CHANNELS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire spi_pkg::job_t q_job,
  output logic               pop,
  spi_out_if.source          out_ch
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIV_W = $clog2(spi_pkg::T_FRAC_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  state_t             state_r;
  logic [DIV_W-1:0]   div_cnt_r;
  logic [31:0]        rem_r;
  logic [31:0]        total_r;
  logic [14:0]        quo_r;
  logic [16:0]        t_r;
  logic               act_r;
  logic               frz_r;
  logic [CH_W-1:0]    ch_cnt_r;

  logic signed [16:0] start_mem [CHANNELS];
  logic signed [16:0] end_mem [CHANNELS];

  // Pipeline: memory read, multiply, round and clamp
  logic               s1_v_r;
  logic signed [16:0] s1_a0_r;
  logic signed [16:0] s1_a1_r;
  logic [16:0]        s1_t_r;
  logic [CH_W-1:0]    s1_ch_r;
  logic               s1_last_r;
  logic               s1_act_r;
  logic               s1_frz_r;

  logic               s2_v_r;
  logic signed [34:0] s2_prod_r;
  logic signed [16:0] s2_a0_r;
  logic [CH_W-1:0]    s2_ch_r;
  logic               s2_last_r;
  logic               s2_act_r;
  logic               s2_frz_r;

  logic               out_v_r;
  logic [3:0]         out_ch_r;
  logic [15:0]        out_angle_r;
  logic               out_last_r;
  logic               out_act_r;
  logic               out_frz_r;

  logic               adv;
  logic               issue;
  logic               ch_last;
  logic [31:0]        rem2;
  logic               rem_ge;
  logic [CH_W-1:0]    widx;
  logic signed [17:0] diff;
  logic signed [17:0] t_s;
  logic signed [35:0] prod_full;
  logic signed [34:0] rnd;
  logic signed [18:0] q;
  logic signed [19:0] asum;
  logic [15:0]        angle_clamped;

  assign adv     = !out_v_r || out_ch.ready;
  assign pop     = (state_r == ST_IDLE) && q_valid;
  assign issue   = (state_r == ST_RUN) && adv;
  assign ch_last = ch_cnt_r == CH_W'(CHANNELS - 1);
  assign widx    = CH_W'(q_job.channel);

  // One restoring divide step per cycle
  assign rem2   = {rem_r[30:0], 1'b0};
  assign rem_ge = rem2 >= total_r;

  // Multiply and round arithmetic
  assign diff      = 18'(s1_a1_r) - 18'(s1_a0_r);
  assign t_s       = $signed({1'b0, s1_t_r});
  assign prod_full = diff * t_s;
  assign rnd       = s2_prod_r + 35'sd32768;
  assign q         = rnd[34:16];
  assign asum      = 20'(s2_a0_r) + 20'(q);

  always_comb begin
    if (asum[19]) begin
      angle_clamped = '0;
    end else if (asum > $signed({4'd0, spi_pkg::ANGLE_MAX})) begin
      angle_clamped = spi_pkg::ANGLE_MAX;
    end else begin
      angle_clamped = asum[15:0];
    end
  end

  // Sequence jobs: take from queue, divide, issue channels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
      ch_cnt_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid && q_job.op == spi_pkg::OP_TICK) begin
            ch_cnt_r  <= '0;
            div_cnt_r <= '0;
            state_r   <= (q_job.tsel == spi_pkg::TS_DIV) ? ST_DIV : ST_RUN;
          end
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_W'(spi_pkg::T_FRAC_W - 1)) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (adv) begin
            ch_cnt_r <= ch_cnt_r + 1'b1;
            if (ch_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Latch tick parameters and run the divider
  always_ff @(posedge clk) begin
    if (pop && q_job.op == spi_pkg::OP_TICK) begin
      act_r   <= q_job.still_active;
      frz_r   <= q_job.freeze;
      rem_r   <= q_job.elapsed;
      total_r <= q_job.total;
      quo_r   <= '0;
      case (q_job.tsel)
        spi_pkg::TS_ONE:  t_r <= spi_pkg::T_ONE;
        spi_pkg::TS_ZERO: t_r <= '0;
        default:          t_r <= '0;
      endcase
    end else if (state_r == ST_DIV) begin
      rem_r <= rem_ge ? rem2 - total_r : rem2;
      quo_r <= {quo_r[13:0], rem_ge};
      if (div_cnt_r == DIV_W'(spi_pkg::T_FRAC_W - 1)) begin
        t_r <= {1'b0, quo_r, rem_ge};
      end
    end
  end

  // Write pose stores on load jobs, read them on issue
  always_ff @(posedge clk) begin
    if (pop && q_job.op == spi_pkg::OP_LOAD_START) begin
      start_mem[widx] <= q_job.angle;
    end
    if (pop && q_job.op == spi_pkg::OP_LOAD_END) begin
      end_mem[widx] <= q_job.angle;
    end
    if (issue) begin
      s1_a0_r   <= start_mem[ch_cnt_r];
      s1_a1_r   <= end_mem[ch_cnt_r];
      s1_t_r    <= t_r;
      s1_ch_r   <= ch_cnt_r;
      s1_last_r <= ch_last;
      s1_act_r  <= act_r;
      s1_frz_r  <= frz_r;
    end
  end

  // Advance the pipeline payload when the output moves
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r   <= prod_full[34:0];
      s2_a0_r     <= s1_a0_r;
      s2_ch_r     <= s1_ch_r;
      s2_last_r   <= s1_last_r;
      s2_act_r    <= s1_act_r;
      s2_frz_r    <= s1_frz_r;
      out_ch_r    <= 4'(s2_ch_r);
      out_angle_r <= angle_clamped;
      out_last_r  <= s2_last_r;
      out_act_r   <= s2_act_r;
      out_frz_r   <= s2_frz_r;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.out_channel  = out_ch_r;
  assign out_ch.angle        = out_angle_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.still_active = out_act_r;
  assign out_ch.freeze       = out_frz_r;

endmodule
`default_nettype wire

FILE: rtl/core/servo_pose_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload                                         Transfer
// in_if    in   mode, channel, pose_angle, hold_after, now_ms   valid & ready
// out_if   out  out_channel, angle, last, still_active, freeze  valid & ready
// cfg_if   in   blend_duration_ms                               valid & ready
//
// Loads and begins are each taken in a single handshake; an item enters whenever the
// two-entry job queue has room. A tick inside the blend first runs the
// serial restoring divider, then issues one channel per cycle, while the output
// accepts, through a three-stage read/multiply/clamp pipeline. Reset is
// synchronous, active low, and clears control state only; pose stores are
// undefined until loaded. A stalled output freezes the whole pipeline; the
// queue then fills and in_if.ready drops.
module servo_pose_interpolator #(
  parameter int CHANNELS = spi_pkg::CHANNELS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spi_in_if.sink    in_if,
  spi_out_if.source out_if,
  spi_cfg_if.sink   cfg_if
);

  spi_pkg::job_t push_job;
  logic          push_valid;
  logic          q_full;
  logic          pop;
  logic          q_valid;
  spi_pkg::job_t q_job;

  spi_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .cfg_ch     (cfg_if),
    .push_job   (push_job),
    .push_valid (push_valid),
    .q_full     (q_full)
  );

  spi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .q_full     (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_job      (q_job)
  );

  spi_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .out_ch  (out_if)
  );

endmodule
`default_nettype wire
